// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the dirty rectangle tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition in one cycle implies consequence in the same cycle.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Condition in one cycle implies consequence in the next cycle.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/drmt_pkg.sv =====
// Types, codes and helper functions of the dirty rectangle tracker.
package drmt_pkg;

   localparam int TABLE_DEPTH_DEF = 128;
   localparam int MAX_SCREEN = 4096;

   localparam logic [1:0] ACT_MARK  = 2'd0;
   localparam logic [1:0] ACT_DRAIN = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [2:0] REG_SCREEN_W = 3'd0;
   localparam logic [2:0] REG_SCREEN_H = 3'd1;
   localparam logic [2:0] REG_STRATEGY = 3'd2;
   localparam logic [2:0] REG_EX_EN    = 3'd3;
   localparam logic [2:0] REG_EX_LEFT  = 3'd4;
   localparam logic [2:0] REG_EX_TOP   = 3'd5;
   localparam logic [2:0] REG_EX_W     = 3'd6;
   localparam logic [2:0] REG_EX_H     = 3'd7;

   typedef logic signed [18:0] crd_type;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [12:0] w;
      logic [12:0] h;
   } box_type;

   typedef struct packed {
      logic    en;
      box_type data;
   } ring_wr_type;

   typedef struct packed {
      logic       start;
      logic       empty;
      logic       done;
      logic [7:0] held;
      box_type    b;
   } job_type;

   typedef struct packed {
      logic [13:0]        sw;
      logic [13:0]        sh;
      logic               ex_on;
      logic signed [15:0] exl;
      logic signed [15:0] ext;
      logic [14:0]        exw;
      logic [14:0]        exh;
   } cfg_type;

   typedef struct packed {
      logic        v;
      logic [11:0] x;
      logic [11:0] y;
      logic [12:0] w;
      logic [12:0] h;
   } piece_type;

   typedef struct packed {
      logic    ok;
      box_type b;
   } clip_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_FULL, ST_WRITE, ST_SW_SEEK, ST_SW_TAIL,
      ST_SW_CHK, ST_SW_PUT, ST_COLL, ST_READ
   } state_type;

   typedef enum logic [1:0] {PS_IDLE, PS_PREP, PS_COMP, PS_EMIT} pstate_type;

   function automatic logic overlaps(box_type a, box_type b);
      logic [13:0] ax;
      logic [13:0] bx;
      logic [13:0] ay;
      logic [13:0] by;
      ax = {2'b0, a.x} + {1'b0, a.w};
      bx = {2'b0, b.x} + {1'b0, b.w};
      ay = {2'b0, a.y} + {1'b0, a.h};
      by = {2'b0, b.y} + {1'b0, b.h};
      return !(ax <= {2'b0, b.x} || bx <= {2'b0, a.x} ||
               ay <= {2'b0, b.y} || by <= {2'b0, a.y});
   endfunction

   function automatic box_type grow(box_type a, box_type b);
      logic [13:0] ax;
      logic [13:0] bx;
      logic [13:0] ay;
      logic [13:0] by;
      logic [13:0] x2;
      logic [13:0] y2;
      box_type     r;
      ax = {2'b0, a.x} + {1'b0, a.w};
      bx = {2'b0, b.x} + {1'b0, b.w};
      ay = {2'b0, a.y} + {1'b0, a.h};
      by = {2'b0, b.y} + {1'b0, b.h};
      r.x = (a.x < b.x) ? a.x : b.x;
      r.y = (a.y < b.y) ? a.y : b.y;
      x2 = (ax > bx) ? ax : bx;
      y2 = (ay > by) ? ay : by;
      r.w = 13'(x2 - {2'b0, r.x});
      r.h = 13'(y2 - {2'b0, r.y});
      return r;
   endfunction

   // Clips a marked rectangle to the screen; ok is low when nothing is left.
   function automatic clip_type clip_mark(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] w, logic signed [15:0] h,
                                          logic [13:0] sw, logic [13:0] sh);
      crd_type  xs;
      crd_type  ys;
      crd_type  xe;
      crd_type  ye;
      crd_type  dx;
      crd_type  dy;
      clip_type r;
      xe = crd_type'(x) + crd_type'(w);
      ye = crd_type'(y) + crd_type'(h);
      xs = (x < 0) ? '0 : crd_type'(x);
      ys = (y < 0) ? '0 : crd_type'(y);
      if (xe > crd_type'({5'b0, sw})) xe = crd_type'({5'b0, sw});
      if (ye > crd_type'({5'b0, sh})) ye = crd_type'({5'b0, sh});
      dx = xe - xs;
      dy = ye - ys;
      r.ok = (w > 0) && (h > 0) && (xe > xs) && (ye > ys);
      r.b.x = xs[11:0];
      r.b.y = ys[11:0];
      r.b.w = dx[12:0];
      r.b.h = dy[12:0];
      return r;
   endfunction

   // One copy piece, clipped to the screen; v is low when it is empty.
   function automatic piece_type make_piece(crd_type x, crd_type y, crd_type w, crd_type h,
                                            logic [13:0] sw, logic [13:0] sh);
      crd_type   xs;
      crd_type   ys;
      crd_type   xe;
      crd_type   ye;
      crd_type   swc;
      crd_type   shc;
      crd_type   dx;
      crd_type   dy;
      piece_type r;
      swc = crd_type'({5'b0, sw});
      shc = crd_type'({5'b0, sh});
      xs = (x < 0) ? '0 : x;
      ys = (y < 0) ? '0 : y;
      xe = x + w;
      ye = y + h;
      r.v = (w > 0) && (h > 0) && (xe > xs) && (ye > ys) && (xs < swc) && (ys < shc);
      if (xe > swc) xe = swc;
      if (ye > shc) ye = shc;
      dx = xe - xs;
      dy = ye - ys;
      r.x = xs[11:0];
      r.y = ys[11:0];
      r.w = dx[12:0];
      r.h = dy[12:0];
      return r;
   endfunction

endpackage

// ===== rtl/drmt_cell.sv =====
// One cell of the rectangle ring: holds one table entry and passes it on each cycle.
module drmt_cell (
   input  logic              clock,
   input  drmt_pkg::box_type d,
   output drmt_pkg::box_type q
);

   drmt_pkg::box_type q_ff;

   always_ff @(posedge clock) begin
      q_ff <= d;
   end

   assign q = q_ff;

endmodule

// ===== rtl/drmt_ring.sv =====
// Rotating ring of table cells with the index of the entry at the head cell.
module drmt_ring #(
   parameter int DEPTH = drmt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  drmt_pkg::ring_wr_type        wr,
   output drmt_pkg::box_type            head,
   output logic [$clog2(DEPTH)-1:0]     hidx
);

   localparam int IW = $clog2(DEPTH);

   drmt_pkg::box_type q [DEPTH];
   drmt_pkg::box_type tail_d;
   logic [IW-1:0]     hidx_ff;
   logic [IW-1:0]     hidx_in;

   // The head entry re-enters at the tail, replaced when a write is due.
   assign tail_d = wr.en ? wr.data : q[0];

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      if (k == DEPTH - 1) begin : g_last
         drmt_cell u_cell (.clock(clock), .d(tail_d), .q(q[k]));
      end else begin : g_mid
         drmt_cell u_cell (.clock(clock), .d(q[k+1]), .q(q[k]));
      end
   end

   assign hidx_in = (hidx_ff == IW'(DEPTH - 1)) ? '0 : hidx_ff + IW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         hidx_ff <= '0;
      end else begin
         hidx_ff <= hidx_in;
      end
   end

   assign head = q[0];
   assign hidx = hidx_ff;

endmodule

// ===== rtl/drmt_piece.sv =====
// Drain unit: splits one entry into copy pieces and drives the result register.
module drmt_piece (
   input  logic              clock,
   input  logic              reset,
   input  drmt_pkg::job_type job,
   input  drmt_pkg::cfg_type cfg,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [11:0]       rsp_piece_left,
   output logic [11:0]       rsp_piece_top,
   output logic [12:0]       rsp_piece_width,
   output logic [12:0]       rsp_piece_height,
   output logic              rsp_piece_valid,
   output logic              rsp_last_of_run,
   output logic              rsp_frame_done,
   output logic [7:0]        rsp_entries_held
);

   localparam logic [1:0] PC_TOP    = 2'd0;
   localparam logic [1:0] PC_BOTTOM = 2'd1;
   localparam logic [1:0] PC_LEFT   = 2'd2;
   localparam logic [1:0] PC_RIGHT  = 2'd3;

   drmt_pkg::pstate_type state_ff, state_in;
   drmt_pkg::box_type    b_ff;
   logic                 done_ff, empty_ff;
   logic [7:0]           held_ff;
   drmt_pkg::crd_type    x0_ff, y0_ff, x1_ff, y1_ff, ex1_ff, ey1_ff;
   drmt_pkg::crd_type    x0_in, y0_in, x1_in, y1_in, ex1_in, ey1_in;
   logic                 act_ff, act_in;
   logic [1:0]           k_ff;
   drmt_pkg::piece_type  buf_ff [4];
   logic [3:0]           mask_ff, mask_in;
   drmt_pkg::piece_type  pc;
   drmt_pkg::crd_type    ex0, ey0, cx, cy, cw, ch;
   logic [1:0]           sel;
   logic [3:0]           sel_oh;
   logic                 load, last;
   drmt_pkg::piece_type  rec;

   logic                 rv_ff;
   drmt_pkg::piece_type  out_ff;
   logic                 last_ff, fdone_ff;
   logic [7:0]           oheld_ff;

   assign ex0 = drmt_pkg::crd_type'(cfg.exl);
   assign ey0 = drmt_pkg::crd_type'(cfg.ext);

   // Entry edges clipped to the screen, and the far edges of the exclusion box.
   always_comb begin
      x0_in  = drmt_pkg::crd_type'({7'b0, b_ff.x});
      y0_in  = drmt_pkg::crd_type'({7'b0, b_ff.y});
      x1_in  = x0_in + drmt_pkg::crd_type'({6'b0, b_ff.w});
      y1_in  = y0_in + drmt_pkg::crd_type'({6'b0, b_ff.h});
      if (x1_in > drmt_pkg::crd_type'({5'b0, cfg.sw})) x1_in = drmt_pkg::crd_type'({5'b0, cfg.sw});
      if (y1_in > drmt_pkg::crd_type'({5'b0, cfg.sh})) y1_in = drmt_pkg::crd_type'({5'b0, cfg.sh});
      act_in = !empty_ff && (x1_in > x0_in) && (y1_in > y0_in);
      ex1_in = ex0 + drmt_pkg::crd_type'({4'b0, cfg.exw});
      ey1_in = ey0 + drmt_pkg::crd_type'({4'b0, cfg.exh});
   end

   always_comb begin
      cx = x0_ff;
      cy = y0_ff;
      cw = x1_ff - x0_ff;
      ch = y1_ff - y0_ff;
      if (cfg.ex_on) begin
         case (k_ff)
            PC_TOP: begin
               ch = ey0 - y0_ff;
            end
            PC_BOTTOM: begin
               cy = ey1_ff;
               ch = y1_ff - ey1_ff;
            end
            PC_LEFT: begin
               cy = ey0;
               cw = ex0 - x0_ff;
               ch = ey1_ff - ey0;
            end
            PC_RIGHT: begin
               cx = ex1_ff;
               cy = ey0;
               cw = x1_ff - ex1_ff;
               ch = ey1_ff - ey0;
            end
            default: begin
               cx = x0_ff;
            end
         endcase
      end
      pc = drmt_pkg::make_piece(cx, cy, cw, ch, cfg.sw, cfg.sh);
      if (!act_ff || (!cfg.ex_on && k_ff != PC_TOP)) pc.v = 1'b0;
   end

   always_comb begin
      sel    = 2'd0;
      sel_oh = 4'b0001;
      if (mask_ff[0]) begin
         sel = 2'd0; sel_oh = 4'b0001;
      end else if (mask_ff[1]) begin
         sel = 2'd1; sel_oh = 4'b0010;
      end else if (mask_ff[2]) begin
         sel = 2'd2; sel_oh = 4'b0100;
      end else begin
         sel = 2'd3; sel_oh = 4'b1000;
      end
      last = ((mask_ff & ~sel_oh) == 4'b0000);
      rec  = (mask_ff == 4'b0000) ? '0 : buf_ff[sel];
      load = (state_ff == drmt_pkg::PS_EMIT) && (!rv_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drmt_pkg::PS_IDLE: if (job.start) state_in = drmt_pkg::PS_PREP;
         drmt_pkg::PS_PREP: state_in = drmt_pkg::PS_COMP;
         drmt_pkg::PS_COMP: if (k_ff == PC_RIGHT) state_in = drmt_pkg::PS_EMIT;
         drmt_pkg::PS_EMIT: if (load && last) state_in = drmt_pkg::PS_IDLE;
         default: state_in = drmt_pkg::PS_IDLE;
      endcase
   end

   always_comb begin
      mask_in = mask_ff;
      case (state_ff)
         drmt_pkg::PS_PREP: mask_in = 4'b0000;
         drmt_pkg::PS_COMP: mask_in = mask_ff | (pc.v ? (4'b0001 << k_ff) : 4'b0000);
         drmt_pkg::PS_EMIT: if (load) mask_in = mask_ff & ~sel_oh;
         default: mask_in = mask_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drmt_pkg::PS_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (job.start && state_ff == drmt_pkg::PS_IDLE) begin
         b_ff     <= job.b;
         done_ff  <= job.done;
         empty_ff <= job.empty;
         held_ff  <= job.held;
         k_ff     <= PC_TOP;
      end
      if (state_ff == drmt_pkg::PS_PREP) begin
         x0_ff  <= x0_in;
         y0_ff  <= y0_in;
         x1_ff  <= x1_in;
         y1_ff  <= y1_in;
         ex1_ff <= ex1_in;
         ey1_ff <= ey1_in;
         act_ff <= act_in;
      end
      if (state_ff == drmt_pkg::PS_COMP) begin
         buf_ff[k_ff] <= pc;
         k_ff         <= k_ff + 2'd1;
      end
      if (load) begin
         out_ff   <= rec;
         last_ff  <= last;
         fdone_ff <= last && done_ff;
         oheld_ff <= held_ff;
      end
   end

   assign busy             = (state_ff != drmt_pkg::PS_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_piece_left   = out_ff.x;
   assign rsp_piece_top    = out_ff.y;
   assign rsp_piece_width  = out_ff.w;
   assign rsp_piece_height = out_ff.h;
   assign rsp_piece_valid  = out_ff.v;
   assign rsp_last_of_run  = last_ff;
   assign rsp_frame_done   = fdone_ff;
   assign rsp_entries_held = oheld_ff;

endmodule

// ===== rtl/dirty_rect_merge_tracker_top.sv =====
// Dirty rectangle tracker: the table of dirty entries circulates in a ring of
// TABLE_DEPTH cells, one entry passing the head cell per cycle, and every table
// access waits for its entry to reach the head. A mark is clipped when it is
// accepted and then searched for overlaps (the search waits for entry zero to
// reach the head and then passes over the whole ring). A merge adds the
// absorbing sweep, a move of the last entry into the slot of each entry absorbed
// and the write-back of the merged entry; an append is written when its slot
// reaches the head after the search, and a table overflow first folds the table
// into one entry. A drain waits for its entry (after a collapse of the whole
// table when that is done first), then forms its pieces and gives one result per
// cycle while the output does not stall. The table contents need no clearing
// after reset.
module dirty_rect_merge_tracker_top #(
   parameter int TABLE_DEPTH = drmt_pkg::TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_rect_left,
   input  logic signed [15:0] req_rect_top,
   input  logic signed [15:0] req_rect_width,
   input  logic signed [15:0] req_rect_height,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_piece_left,
   output logic [11:0]        rsp_piece_top,
   output logic [12:0]        rsp_piece_width,
   output logic [12:0]        rsp_piece_height,
   output logic               rsp_piece_valid,
   output logic               rsp_last_of_run,
   output logic               rsp_frame_done,
   output logic [7:0]         rsp_entries_held,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

`include "assert_macros.svh"

   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int CNW = $clog2(TABLE_DEPTH + 1);

   logic [12:0]        sw_ff, sh_ff;
   logic               strat_ff, exen_ff;
   logic signed [15:0] exl_ff, ext_ff;
   logic [14:0]        exw_ff, exh_ff;
   drmt_pkg::cfg_type  cfg;

   drmt_pkg::state_type   state_ff, state_in;
   logic [CNW-1:0]        cnt_ff, cnt_in;
   logic [IW-1:0]         di_ff, di_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [IW-1:0]         wi_ff, wi_in;
   logic [CNW-1:0]        j_ff, j_in;
   logic                  on_ff, on_in;
   drmt_pkg::box_type     m_ff, m_in;
   drmt_pkg::box_type     t_ff, t_in;

   drmt_pkg::ring_wr_type wr;
   drmt_pkg::box_type     head;
   logic [IW-1:0]         hidx;
   logic [CNW-1:0]        hidx_c, hidx_c1, i_c, di_c, cnt_m1;
   drmt_pkg::job_type     job;
   drmt_pkg::clip_type    clip;
   logic                  p_busy, ov_head, ov_t, live, accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff    <= 13'd640;
         sh_ff    <= 13'd480;
         strat_ff <= 1'b0;
         exen_ff  <= 1'b0;
         exl_ff   <= '0;
         ext_ff   <= '0;
         exw_ff   <= 15'd1;
         exh_ff   <= 15'd1;
      end else if (csr_valid) begin
         case (csr_index)
            drmt_pkg::REG_SCREEN_W: sw_ff    <= csr_data[12:0];
            drmt_pkg::REG_SCREEN_H: sh_ff    <= csr_data[12:0];
            drmt_pkg::REG_STRATEGY: strat_ff <= csr_data[0];
            drmt_pkg::REG_EX_EN:    exen_ff  <= csr_data[0];
            drmt_pkg::REG_EX_LEFT:  exl_ff   <= csr_data;
            drmt_pkg::REG_EX_TOP:   ext_ff   <= csr_data;
            drmt_pkg::REG_EX_W:     exw_ff   <= csr_data[14:0];
            drmt_pkg::REG_EX_H:     exh_ff   <= csr_data[14:0];
            default:                sw_ff    <= sw_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      cfg.sw    = ({1'b0, sw_ff} > 14'(drmt_pkg::MAX_SCREEN)) ?
                  14'(drmt_pkg::MAX_SCREEN) : {1'b0, sw_ff};
      cfg.sh    = ({1'b0, sh_ff} > 14'(drmt_pkg::MAX_SCREEN)) ?
                  14'(drmt_pkg::MAX_SCREEN) : {1'b0, sh_ff};
      cfg.ex_on = exen_ff && (exw_ff != '0) && (exh_ff != '0);
      cfg.exl   = exl_ff;
      cfg.ext   = ext_ff;
      cfg.exw   = exw_ff;
      cfg.exh   = exh_ff;
   end

   drmt_ring #(.DEPTH(TABLE_DEPTH)) u_ring (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .head  (head),
      .hidx  (hidx)
   );

   drmt_piece u_piece (
      .clock            (clock),
      .reset            (reset),
      .job              (job),
      .cfg              (cfg),
      .busy             (p_busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_piece_left   (rsp_piece_left),
      .rsp_piece_top    (rsp_piece_top),
      .rsp_piece_width  (rsp_piece_width),
      .rsp_piece_height (rsp_piece_height),
      .rsp_piece_valid  (rsp_piece_valid),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_entries_held (rsp_entries_held)
   );

   assign req_ready = (state_ff == drmt_pkg::ST_IDLE) && !p_busy;
   assign accept    = req_valid && req_ready;
   assign hidx_c    = CNW'(hidx);
   assign hidx_c1   = hidx_c + CNW'(1);
   assign i_c       = CNW'(i_ff);
   assign di_c      = CNW'(di_ff);
   assign cnt_m1    = cnt_ff - CNW'(1);
   assign ov_head   = drmt_pkg::overlaps(head, m_ff);
   assign ov_t      = drmt_pkg::overlaps(t_ff, m_ff);
   assign live      = on_ff || (hidx == '0);
   assign clip      = drmt_pkg::clip_mark(req_rect_left, req_rect_top, req_rect_width,
                                          req_rect_height, cfg.sw, cfg.sh);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drmt_pkg::ST_IDLE: begin
            if (accept && req_action == drmt_pkg::ACT_MARK && clip.ok) begin
               state_in = drmt_pkg::ST_SCAN;
            end else if (accept && req_action == drmt_pkg::ACT_DRAIN && di_c < cnt_ff) begin
               if (strat_ff && di_ff == '0 && cnt_ff > CNW'(1)) begin
                  state_in = drmt_pkg::ST_COLL;
               end else begin
                  state_in = drmt_pkg::ST_READ;
               end
            end
         end
         drmt_pkg::ST_SCAN: begin
            if (live && hidx_c < cnt_ff && ov_head) begin
               state_in = drmt_pkg::ST_SW_SEEK;
            end else if (live && hidx_c1 >= cnt_ff) begin
               state_in = (cnt_ff < CNW'(TABLE_DEPTH)) ? drmt_pkg::ST_WRITE : drmt_pkg::ST_FULL;
            end
         end
         drmt_pkg::ST_FULL: begin
            if (live && hidx == IW'(TABLE_DEPTH - 1)) state_in = drmt_pkg::ST_WRITE;
         end
         drmt_pkg::ST_WRITE: begin
            if (hidx == wi_ff) state_in = drmt_pkg::ST_IDLE;
         end
         drmt_pkg::ST_SW_SEEK: begin
            if (j_ff >= cnt_ff) begin
               state_in = drmt_pkg::ST_WRITE;
            end else if (j_ff != i_c && hidx_c == j_ff && ov_head && i_c != cnt_m1) begin
               state_in = drmt_pkg::ST_SW_TAIL;
            end
         end
         drmt_pkg::ST_SW_TAIL: begin
            if (hidx_c == cnt_m1) state_in = drmt_pkg::ST_SW_CHK;
         end
         drmt_pkg::ST_SW_CHK: begin
            if (j_ff >= cnt_ff) begin
               state_in = drmt_pkg::ST_WRITE;
            end else if (ov_t) begin
               state_in = (i_c == cnt_m1) ? drmt_pkg::ST_SW_SEEK : drmt_pkg::ST_SW_TAIL;
            end else begin
               state_in = drmt_pkg::ST_SW_PUT;
            end
         end
         drmt_pkg::ST_SW_PUT: begin
            if (hidx_c == j_ff) state_in = drmt_pkg::ST_SW_SEEK;
         end
         drmt_pkg::ST_COLL: begin
            if (live && hidx_c == cnt_m1) state_in = drmt_pkg::ST_IDLE;
         end
         drmt_pkg::ST_READ: begin
            if (hidx == di_ff) state_in = drmt_pkg::ST_IDLE;
         end
         default: state_in = drmt_pkg::ST_IDLE;
      endcase
   end

   // Datapath, table writes and drain jobs.
   always_comb begin
      cnt_in   = cnt_ff;
      di_in    = di_ff;
      i_in     = i_ff;
      wi_in    = wi_ff;
      j_in     = j_ff;
      on_in    = on_ff;
      m_in     = m_ff;
      t_in     = t_ff;
      wr.en    = 1'b0;
      wr.data  = m_ff;
      job.start = 1'b0;
      job.empty = 1'b0;
      job.done  = 1'b0;
      job.held  = '0;
      job.b     = head;
      case (state_ff)
         drmt_pkg::ST_IDLE: begin
            on_in = 1'b0;
            if (accept) begin
               case (req_action)
                  drmt_pkg::ACT_MARK: begin
                     m_in = clip.b;
                  end
                  drmt_pkg::ACT_DRAIN: begin
                     if (di_c >= cnt_ff) begin
                        job.start = 1'b1;
                        job.empty = 1'b1;
                        job.done  = 1'b1;
                        cnt_in    = '0;
                        di_in     = '0;
                     end
                  end
                  drmt_pkg::ACT_CLEAR: begin
                     cnt_in = '0;
                     di_in  = '0;
                  end
                  default: begin
                     on_in = 1'b0;
                  end
               endcase
            end
         end
         drmt_pkg::ST_SCAN: begin
            if (live) begin
               on_in = 1'b1;
               if (hidx_c < cnt_ff && ov_head) begin
                  i_in = hidx;
                  m_in = drmt_pkg::grow(head, m_ff);
                  j_in = '0;
               end else if (hidx_c1 >= cnt_ff) begin
                  on_in = 1'b0;
                  if (cnt_ff < CNW'(TABLE_DEPTH)) begin
                     wi_in  = cnt_ff[IW-1:0];
                     cnt_in = cnt_ff + CNW'(1);
                  end
               end
            end
         end
         drmt_pkg::ST_FULL: begin
            // Table overflow: everything folds into one bounding box at entry zero.
            if (live) begin
               on_in = 1'b1;
               m_in  = drmt_pkg::grow(m_ff, head);
               if (hidx == IW'(TABLE_DEPTH - 1)) begin
                  wi_in  = '0;
                  cnt_in = CNW'(1);
               end
            end
         end
         drmt_pkg::ST_WRITE: begin
            if (hidx == wi_ff) wr.en = 1'b1;
         end
         drmt_pkg::ST_SW_SEEK: begin
            if (j_ff >= cnt_ff) begin
               wi_in = i_ff;
            end else if (j_ff == i_c) begin
               j_in = j_ff + CNW'(1);
            end else if (hidx_c == j_ff) begin
               if (ov_head) begin
                  m_in = drmt_pkg::grow(m_ff, head);
                  // When the merged entry is the last one it moves into this slot.
                  if (i_c == cnt_m1) begin
                     i_in   = j_ff[IW-1:0];
                     cnt_in = cnt_m1;
                     j_in   = j_ff + CNW'(1);
                  end
               end else begin
                  j_in = j_ff + CNW'(1);
               end
            end
         end
         drmt_pkg::ST_SW_TAIL: begin
            if (hidx_c == cnt_m1) begin
               t_in   = head;
               cnt_in = cnt_m1;
            end
         end
         drmt_pkg::ST_SW_CHK: begin
            if (j_ff >= cnt_ff) begin
               wi_in = i_ff;
            end else if (ov_t) begin
               m_in = drmt_pkg::grow(m_ff, t_ff);
               if (i_c == cnt_m1) begin
                  i_in   = j_ff[IW-1:0];
                  cnt_in = cnt_m1;
                  j_in   = j_ff + CNW'(1);
               end
            end
         end
         drmt_pkg::ST_SW_PUT: begin
            if (hidx_c == j_ff) begin
               wr.en   = 1'b1;
               wr.data = t_ff;
               j_in    = j_ff + CNW'(1);
            end
         end
         drmt_pkg::ST_COLL: begin
            if (live) begin
               on_in = 1'b1;
               m_in  = (hidx == '0) ? head : drmt_pkg::grow(m_ff, head);
               if (hidx_c == cnt_m1) begin
                  job.start = 1'b1;
                  job.done  = 1'b1;
                  job.b     = drmt_pkg::grow(m_ff, head);
                  cnt_in    = '0;
                  di_in     = '0;
               end
            end
         end
         drmt_pkg::ST_READ: begin
            if (hidx == di_ff) begin
               job.start = 1'b1;
               if (di_c + CNW'(1) >= cnt_ff) begin
                  job.done = 1'b1;
                  cnt_in   = '0;
                  di_in    = '0;
               end else begin
                  job.held = 8'(cnt_ff);
                  di_in    = di_ff + IW'(1);
               end
            end
         end
         default: begin
            on_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drmt_pkg::ST_IDLE;
         cnt_ff   <= '0;
         di_ff    <= '0;
         on_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         di_ff    <= di_in;
         on_ff    <= on_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff  <= i_in;
      wi_ff <= wi_in;
      j_ff  <= j_in;
      m_ff  <= m_in;
      t_ff  <= t_in;
   end

   `ASSERT_NXT(a_run_continues, clock, reset, rsp_valid && !rsp_last_of_run, rsp_valid)
   `ASSERT_IMP(a_done_empty, clock, reset, rsp_valid && rsp_frame_done,
               rsp_entries_held == 8'd0 && rsp_last_of_run)
   `ASSERT_IMP(a_piece_size, clock, reset, rsp_valid && rsp_piece_valid,
               rsp_piece_width != 13'd0 && rsp_piece_height != 13'd0)

endmodule
